[rtl/bmf_pkg.sv]
package bmf_pkg;

  // Batch geometry
  localparam int unsigned SAMPLE_COUNT = 16;
  localparam int unsigned SAMPLE_BITS  = 10;

  // Fill counter runs 0 .. SAMPLE_COUNT-1
  localparam int unsigned FILL_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(SAMPLE_COUNT - 1);

  // Middle positions of the sorted batch
  localparam int unsigned MID_HI = SAMPLE_COUNT / 2;
  localparam int unsigned MID_LO = (SAMPLE_COUNT > 1) ? (SAMPLE_COUNT / 2 - 1) : 0;
  localparam bit          COUNT_ODD = (SAMPLE_COUNT % 2) != 0;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // Link from one cell to its right neighbor
  typedef struct packed {
    sample_t value;  // stored entry
    logic    gt;     // entry is empty or greater than the incoming sample
  } link_t;

endpackage

[rtl/bmf_sample_if.sv]
interface bmf_sample_if import bmf_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

[rtl/bmf_median_if.sv]
interface bmf_median_if import bmf_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t median;

  modport source (output valid, output median, input ready);
  modport sink (input valid, input median, output ready);
endinterface

[rtl/block_median_filter_unit.sv]
// Batch median filter. Samples arrive on sample_i and are kept sorted by a
// row of SAMPLE_COUNT insertion cells: each cell compares the new sample with
// its entry and either keeps it, takes its left neighbor's entry or takes the
// sample, so one sample is accepted per cycle. After every SAMPLE_COUNT-th
// sample the median of that batch (middle entry, or the floor of the mean of
// the two middle entries for an even count) is loaded into the output register
// and shown on median_o in the cycle after the closing sample; the next batch
// starts at once. The closing sample of a batch waits only while an earlier
// median is still held in the output register and not taken.
module block_median_filter_unit import bmf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  bmf_sample_if.sink         sample_i,
  bmf_median_if.source       median_o
);

  logic [FILL_W-1:0] fill_q;
  logic [FILL_W-1:0] fill_d;
  logic              accept;
  logic              closing;
  logic              out_valid_q;
  logic              out_valid_d;
  sample_t           median_q;
  sample_t           median_d;
  link_t             links [SAMPLE_COUNT];
  sample_t           next_val [SAMPLE_COUNT];

  assign closing        = (fill_q == FILL_LAST);
  assign sample_i.ready = !closing || !out_valid_q || median_o.ready;
  assign accept         = sample_i.valid && sample_i.ready;

  // Build the insertion chain
  for (genvar i = 0; i < SAMPLE_COUNT; i++) begin : g_cell
    link_t left;
    if (i == 0) begin : g_first
      assign left = '{value: '0, gt: 1'b0};
    end else begin : g_rest
      assign left = links[i-1];
    end
    bmf_cell u_cell (
      .clk_i      (clk_i),
      .en_i       (accept),
      .sample_i   (sample_i.sample),
      .occupied_i (FILL_W'(i) < fill_q),
      .left_i     (left),
      .link_o     (links[i]),
      .next_o     (next_val[i])
    );
  end

  // Pick the median from the entries the closing sample leaves behind
  if (COUNT_ODD) begin : g_odd
    assign median_d = next_val[MID_HI];
  end else begin : g_even
    logic [SAMPLE_BITS:0] mid_sum;
    assign mid_sum  = {1'b0, next_val[MID_HI]} + {1'b0, next_val[MID_LO]};
    assign median_d = mid_sum[SAMPLE_BITS:1];
  end

  // Advance the fill count, wrap at the end of a batch
  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      fill_d = closing ? '0 : fill_q + 1'b1;
    end
  end

  // Hold the result until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (median_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (accept && closing) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && closing) begin
      median_q <= median_d;
    end
  end

  assign median_o.valid  = out_valid_q;
  assign median_o.median = median_q;

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_LAST)
    else $error("fill count beyond batch size");

  a_close_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && closing |=> out_valid_q && fill_q == '0)
    else $error("closing sample did not load a median");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !median_o.ready && closing |-> !sample_i.ready)
    else $error("pending median could be overwritten");

  a_mid_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && closing |-> next_val[MID_LO] <= next_val[MID_HI])
    else $error("middle entries out of order");
`endif

endmodule

[rtl/bmf_cell.sv]
module bmf_cell import bmf_pkg::*; (
  input  logic    clk_i,
  input  logic    en_i,
  input  sample_t sample_i,
  input  logic    occupied_i,
  input  link_t   left_i,
  output link_t   link_o,
  output sample_t next_o
);

  sample_t value_q;
  sample_t value_d;
  logic    gt;

  // Empty cells act as plus infinity
  assign gt = !occupied_i || (value_q > sample_i);

  // Shift in the left entry if it is also greater, else take the new sample
  always_comb begin
    value_d = value_q;
    if (en_i && gt) begin
      value_d = left_i.gt ? left_i.value : sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o.value = value_q;
  assign link_o.gt    = gt;
  assign next_o       = value_d;

endmodule

[bench/block_median_filter_unit_tb.sv]
`timescale 1ns / 1ps

module block_median_filter_unit_tb;
  import bmf_pkg::*;

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 4;
  localparam int RANDOM_ITEMS  = 1930;
  localparam int CYCLE_LIMIT   = 60000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int IDLE_PCT      = 17;
  localparam int NO_TYPED      = -1;

  // Sender runs without gaps over this range of random requests
  localparam int SEND_BURST_LO = 700;
  localparam int SEND_BURST_HI = 1100;

  // Receiver schedule, in cycles after reset
  localparam int HOLD_START    = 600;
  localparam int HOLD_END      = 900;
  localparam int RECV_BURST_HI = 1700;

  typedef enum int {
    MODE_UNIFORM,
    MODE_CLUSTER,
    MODE_RISING,
    MODE_FALLING,
    MODE_EXTREME
  } value_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  bmf_sample_if sample_bus ();
  bmf_median_if median_bus ();

  block_median_filter_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_bus),
    .median_o (median_bus)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Directed requests: a batch of extremes with repeated values (the two
  // middle entries are both full scale, so the pair sum needs the extra bit),
  // then the opening of the next batch
  localparam int DIR_ROWS = 20;
  int dir_sample [DIR_ROWS] = '{
    1023, 0, 1023, 0, 1023, 0, 1023, 0, 1023, 0, 1023, 0, 1023, 0, 1023, 1023,
    512, 511, 1, 1022
  };
  int dir_median [DIR_ROWS] = '{
    NO_TYPED, NO_TYPED, NO_TYPED, NO_TYPED, NO_TYPED, NO_TYPED, NO_TYPED, NO_TYPED,
    NO_TYPED, NO_TYPED, NO_TYPED, NO_TYPED, NO_TYPED, NO_TYPED, NO_TYPED, 1023,
    NO_TYPED, NO_TYPED, NO_TYPED, NO_TYPED
  };

  // Predicted batch state and medians still owed by the block
  sample_t sorted_batch [SAMPLE_COUNT];
  int      batch_fill = 0;
  sample_t pending_medians [$];

  int error_count = 0;
  int cycle_count = 0;

  // Insert a sample into the sorted batch; close the batch when full
  task absorb_sample(input sample_t value, output bit closed, output sample_t med);
    int                   pos;
    logic [SAMPLE_BITS:0] pair_sum;
    pos = batch_fill;
    while (pos > 0 && sorted_batch[pos-1] > value) begin
      sorted_batch[pos] = sorted_batch[pos-1];
      pos--;
    end
    sorted_batch[pos] = value;
    batch_fill++;
    closed = 1'b0;
    med = '0;
    if (batch_fill == SAMPLE_COUNT) begin
      closed = 1'b1;
      batch_fill = 0;
      if ((SAMPLE_COUNT % 2) != 0) begin
        med = sorted_batch[(SAMPLE_COUNT - 1) / 2];
      end else begin
        pair_sum = {1'b0, sorted_batch[SAMPLE_COUNT/2]} +
                   {1'b0, sorted_batch[SAMPLE_COUNT/2 - 1]};
        med = pair_sum[SAMPLE_BITS:1];
      end
    end
  endtask

  // Offer one request, hold it until taken, then predict its effect
  task automatic offer_sample(input sample_t value, input int typed_median,
                              input bit may_idle);
    bit      closed;
    sample_t med;
    while (may_idle && $urandom_range(99) < IDLE_PCT) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_bus.valid  <= 1'b1;
    sample_bus.sample <= value;
    @(posedge clk_i);
    while (sample_bus.ready !== 1'b1) @(posedge clk_i);
    absorb_sample(value, closed, med);
    if (closed) begin
      if (typed_median != NO_TYPED) pending_medians.push_back(sample_t'(typed_median));
      else pending_medians.push_back(med);
    end
  endtask

  // Reset, then directed and random requests, then drain
  initial begin
    value_mode_e mode;
    int          base;
    int          ramp;
    int          pick;
    sample_t     value;
    rst_ni            <= 1'b0;
    sample_bus.valid  <= 1'b0;
    sample_bus.sample <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      offer_sample(sample_t'(dir_sample[i]), dir_median[i], 1'b1);
    end

    mode = MODE_UNIFORM;
    base = 0;
    ramp = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Change the value pattern every batch length
      if (i % SAMPLE_COUNT == 0) begin
        mode = value_mode_e'($urandom_range(4));
        base = $urandom_range(1020);
        ramp = (mode == MODE_FALLING) ? 1023 - $urandom_range(100) : $urandom_range(100);
      end
      case (mode)
        MODE_CLUSTER: begin
          value = sample_t'(base + $urandom_range(3));
        end
        MODE_RISING: begin
          ramp = ramp + $urandom_range(60);
          if (ramp > 1023) ramp = 1023;
          value = sample_t'(ramp);
        end
        MODE_FALLING: begin
          ramp = ramp - $urandom_range(60);
          if (ramp < 0) ramp = 0;
          value = sample_t'(ramp);
        end
        MODE_EXTREME: begin
          pick = $urandom_range(3);
          value = (pick == 0) ? sample_t'(0) : (pick == 1) ? sample_t'(1023) :
                  (pick == 2) ? sample_t'(1) : sample_t'(1022);
        end
        default: begin
          value = sample_t'($urandom_range(1023));
        end
      endcase
      offer_sample(value, NO_TYPED, (i < SEND_BURST_LO || i >= SEND_BURST_HI));
    end
    sample_bus.valid <= 1'b0;

    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off, a stretch without stalls, then random stalls again
  initial begin
    int recv_cycle;
    recv_cycle = 0;
    median_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (recv_cycle >= HOLD_START && recv_cycle < HOLD_END) begin
        median_bus.ready <= 1'b0;
      end else if (recv_cycle >= HOLD_END && recv_cycle < RECV_BURST_HI) begin
        median_bus.ready <= 1'b1;
      end else begin
        median_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
      recv_cycle++;
    end
  end

  // Compare each taken median with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && median_bus.valid === 1'b1 && median_bus.ready === 1'b1) begin
      if (pending_medians.size() == 0) begin
        $error("median: no batch pending, got %0d", median_bus.median);
        error_count++;
      end else begin
        if (median_bus.median !== pending_medians[0]) begin
          $error("median: expected %0d, got %0d", pending_medians[0], median_bus.median);
          error_count++;
        end
        void'(pending_medians.pop_front());
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
